>>> src/dbpa_pkg.sv
`timescale 1ns / 1ps
package dbpa_pkg;
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOROOM   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NULLFILL = 3'd3;
  localparam logic [2:0] ST_OVERFILL = 3'd4;
  localparam logic [2:0] ST_NOTLIVE  = 3'd5;
  localparam logic [2:0] ST_BADSLOT  = 3'd6;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [15:0] BUCKET_SIZE_RESET = 16'd4096;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch input word, issue first reads
    logic decide;   // evaluate and commit
    logic swap;     // free: write last record into freed slot
    logic finish;   // build result word
  } dbpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic init_done;
    logic is_free_ok;
  } dbpa_stat_t;
endpackage

>>> src/dbpa_datapath.sv
`timescale 1ns / 1ps
module dbpa_datapath #(
  parameter int NUM_BUCKETS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dbpa_pkg::dbpa_cmd_t  cmd,
  output dbpa_pkg::dbpa_stat_t stat,
  input  logic [15:0]          bucket_size,
  input  logic [1:0]           in_op,
  input  logic [7:0]           in_handle,
  input  logic                 in_handle_present,
  input  logic [15:0]          in_face_count,
  input  logic [2:0]           in_direction,
  input  logic signed [31:0]   in_chunk_x,
  input  logic signed [31:0]   in_chunk_y,
  input  logic signed [31:0]   in_chunk_z,
  input  logic [7:0]           in_slot,
  output logic [2:0]           out_status,
  output logic [7:0]           out_bucket,
  output logic [18:0]          out_vertex_count,
  output logic [26:0]          out_first_vertex,
  output logic [2:0]           out_direction,
  output logic signed [31:0]   out_chunk_x,
  output logic signed [31:0]   out_chunk_y,
  output logic signed [31:0]   out_chunk_z,
  output logic [8:0]           out_live_records,
  output logic [8:0]           out_free_buckets
);
  import dbpa_pkg::*;

  localparam int AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CW = $clog2(NUM_BUCKETS + 1);
  localparam logic [CW-1:0] NB = CW'(NUM_BUCKETS);

  typedef struct packed {
    logic [7:0]  bkt;
    logic [18:0] vtx;
    logic [2:0]  dir;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
  } rec_t;

  logic [AW-1:0] fq_mem [NUM_BUCKETS];
  rec_t          rec_mem [NUM_BUCKETS];
  logic [AW-1:0] slot_mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] live_r;

  logic [AW-1:0] head_r, tail_r;
  logic [CW-1:0] free_tot_r, rec_tot_r;
  logic          init_r;
  logic [AW-1:0] init_idx_r;

  // latched word
  logic [1:0]  op_r;
  logic [7:0]  h_r;
  logic        hp_r;
  logic [15:0] fc_r;
  logic [2:0]  dir_r;
  logic [31:0] cx_r, cy_r, cz_r;
  logic [7:0]  rd_r;
  logic        hlive_r;

  // registered memory reads
  logic [AW-1:0] fq_q, slot_q;
  rec_t          last_q, rec_q;

  logic [2:0]    st_r;
  logic [AW-1:0] s_r;       // record slot concerned
  logic          show_r;
  logic [7:0]    shb_r;

  logic hin;
  assign hin = ({8'd0, in_handle} < 16'(NUM_BUCKETS));

  logic [AW-1:0] last_idx;
  assign last_idx = AW'(rec_tot_r - CW'(1));

  // decide step
  logic          ok;
  logic [2:0]    st_nxt;
  logic [AW-1:0] s_nxt;
  always_comb begin
    st_nxt = ST_OK;
    ok = 1'b0;
    s_nxt = slot_q;
    case (op_r)
      OP_ALLOC: begin
        s_nxt = AW'(rec_tot_r);
        if (fc_r > bucket_size || free_tot_r == '0 || rec_tot_r >= NB) st_nxt = ST_NOROOM;
        else if (fc_r == 16'd0) st_nxt = ST_EMPTY;
        else ok = 1'b1;
      end
      OP_FILL: begin
        if (fc_r > bucket_size) st_nxt = ST_OVERFILL;
        else if (!hp_r) st_nxt = ST_NULLFILL;
        else if (!hlive_r) st_nxt = ST_NOTLIVE;
        else ok = 1'b1;
      end
      OP_FREE: begin
        if (hp_r) begin
          if (!hlive_r || rec_tot_r == '0) st_nxt = ST_NOTLIVE;
          else ok = 1'b1;
        end
      end
      default: begin
        s_nxt = AW'(rd_r);
        if ({1'b0, rd_r} >= 9'(rec_tot_r) && CW <= 9) st_nxt = ST_BADSLOT;
        else if ({8'd0, rd_r} >= 16'(rec_tot_r)) st_nxt = ST_BADSLOT;
        else ok = 1'b1;
      end
    endcase
  end

  rec_t new_rec;
  always_comb begin
    new_rec.bkt = 8'(fq_q);
    new_rec.vtx = 19'(fc_r) * 19'd6;
    new_rec.dir = dir_r;
    new_rec.cx = '0;
    new_rec.cy = '0;
    new_rec.cz = '0;
    if (op_r == OP_FILL) begin
      // a live handle's record always holds that handle's bucket
      new_rec.bkt = h_r;
      new_rec.cx = cx_r;
      new_rec.cy = cy_r;
      new_rec.cz = cz_r;
    end
  end

  assign stat.init_done  = init_r;
  assign stat.is_free_ok = (op_r == OP_FREE) && (st_r == ST_OK) && show_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= 1'b0;
      init_idx_r <= '0;
      live_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      free_tot_r <= NB;
      rec_tot_r <= '0;
    end else begin
      if (!init_r) begin
        fq_mem[init_idx_r] <= init_idx_r;
        init_idx_r <= init_idx_r + AW'(1);
        if (init_idx_r == AW'(NUM_BUCKETS - 1)) init_r <= 1'b1;
      end
      if (cmd.decide && ok) begin
        case (op_r)
          OP_ALLOC: begin
            head_r <= (head_r == AW'(NUM_BUCKETS - 1)) ? '0 : head_r + AW'(1);
            free_tot_r <= free_tot_r - CW'(1);
            rec_tot_r <= rec_tot_r + CW'(1);
            live_r[fq_q] <= 1'b1;
          end
          OP_FREE: begin
            fq_mem[tail_r] <= AW'(h_r);
            tail_r <= (tail_r == AW'(NUM_BUCKETS - 1)) ? '0 : tail_r + AW'(1);
            free_tot_r <= free_tot_r + CW'(1);
            rec_tot_r <= rec_tot_r - CW'(1);
            live_r[AW'(h_r)] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_op; h_r <= in_handle; hp_r <= in_handle_present;
      fc_r <= in_face_count; dir_r <= in_direction;
      cx_r <= in_chunk_x; cy_r <= in_chunk_y; cz_r <= in_chunk_z;
      rd_r <= in_slot;
      hlive_r <= in_handle_present && hin && live_r[AW'(in_handle)];
      fq_q <= fq_mem[head_r];
      slot_q <= slot_mem[AW'(in_handle)];
      last_q <= rec_mem[last_idx];
    end
    if (cmd.decide) begin
      st_r <= st_nxt;
      s_r <= s_nxt;
      show_r <= ok;
      if (ok && (op_r == OP_ALLOC || op_r == OP_FILL)) begin
        rec_mem[s_nxt] <= new_rec;
        if (op_r == OP_ALLOC) slot_mem[fq_q] <= s_nxt;
      end
    end
    if (cmd.swap) begin
      rec_mem[s_r] <= last_q;
      slot_mem[AW'(last_q.bkt)] <= s_r;
    end
    rec_q <= rec_mem[cmd.decide ? s_nxt : s_r];
    if (cmd.finish) shb_r <= rec_q.bkt;
  end

  // result
  logic [42:0] fv_full;
  assign fv_full = 43'(bucket_size) * 43'(shb_r) * 43'd6;
  rec_t res_r;
  logic [2:0] res_st_r;
  logic res_show_r;
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r <= rec_q;
      res_st_r <= st_r;
      res_show_r <= show_r && !(op_r == OP_FREE && !hp_r);
    end
  end
  assign out_status       = res_st_r;
  assign out_bucket       = res_show_r ? res_r.bkt : 8'd0;
  assign out_vertex_count = res_show_r ? res_r.vtx : 19'd0;
  assign out_first_vertex = res_show_r ? fv_full[26:0] : 27'd0;
  assign out_direction    = res_show_r ? res_r.dir : 3'd0;
  assign out_chunk_x      = res_show_r ? res_r.cx : 32'sd0;
  assign out_chunk_y      = res_show_r ? res_r.cy : 32'sd0;
  assign out_chunk_z      = res_show_r ? res_r.cz : 32'sd0;
  assign out_live_records = 9'(rec_tot_r);
  assign out_free_buckets = 9'(free_tot_r);
endmodule

>>> src/dbpa_ctrl.sv
`timescale 1ns / 1ps
module dbpa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dbpa_pkg::dbpa_cmd_t  cmd,
  input  dbpa_pkg::dbpa_stat_t stat
);
  import dbpa_pkg::*;

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SWAP   = 6'b001000,
    S_FIN    = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_INIT: if (stat.init_done) state_nxt = S_IDLE;
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt = S_SWAP;
      end
      S_SWAP: begin
        cmd.swap = stat.is_free_ok;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready during result");
  a_cap_decide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.decide) else $error("capture not followed by decide");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif
endmodule

>>> src/draw_bucket_pool_allocator_top.sv
`timescale 1ns / 1ps
// Once a word is accepted, the controller steps through decide, swap and finish
// and then raises out_valid. A new word waits until the result is taken; every
// word walks the same controller sequence: capture, decide, swap, finish, present.
// Reset: synchronous active low; then a clearing pass loads the free queue
// with 0..N-1, and in_ready rises once that pass is done.
module draw_bucket_pool_allocator_top #(
  parameter int NUM_BUCKETS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_bucket_size,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_handle,
  input  logic               in_handle_present,
  input  logic [15:0]        in_face_count,
  input  logic [2:0]         in_direction,
  input  logic signed [31:0] in_chunk_x,
  input  logic signed [31:0] in_chunk_y,
  input  logic signed [31:0] in_chunk_z,
  input  logic [7:0]         in_slot,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [7:0]         out_bucket,
  output logic [18:0]        out_vertex_count,
  output logic [26:0]        out_first_vertex,
  output logic [2:0]         out_direction,
  output logic signed [31:0] out_chunk_x,
  output logic signed [31:0] out_chunk_y,
  output logic signed [31:0] out_chunk_z,
  output logic [8:0]         out_live_records,
  output logic [8:0]         out_free_buckets
);
  import dbpa_pkg::*;

  dbpa_cmd_t  cmd;
  dbpa_stat_t stat;
  logic [15:0] bsize_r;

  // config always accepted
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) bsize_r <= BUCKET_SIZE_RESET;
    else if (cfg_valid) bsize_r <= cfg_bucket_size;
  end

  dbpa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  dbpa_datapath #(.NUM_BUCKETS(NUM_BUCKETS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .bucket_size(bsize_r),
    .in_op, .in_handle, .in_handle_present, .in_face_count, .in_direction,
    .in_chunk_x, .in_chunk_y, .in_chunk_z, .in_slot,
    .out_status, .out_bucket, .out_vertex_count, .out_first_vertex,
    .out_direction, .out_chunk_x, .out_chunk_y, .out_chunk_z,
    .out_live_records, .out_free_buckets
  );
endmodule
